// File: rtl/core/client_resource_pool_table_top_assert.svh
// Assertion macros for the client resource pool table.
`ifndef CLIENT_RESOURCE_POOL_TABLE_TOP_ASSERT_SVH
`define CLIENT_RESOURCE_POOL_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CRPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CRPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/crpt_pkg.sv
// Shared constants and types of the client resource pool table.
`timescale 1ns / 1ps
`default_nettype none

package crpt_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 22;
    localparam int DATA_W      = 16;
    localparam int ENTRY_W     = ID_W + DATA_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] FN_ATTACH  = 2'd0;
    localparam logic [1:0] FN_DETACH  = 2'd1;
    localparam logic [1:0] FN_REQUEST = 2'd2;
    localparam logic [1:0] FN_RELEASE = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DENIED    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              flag;
    } alu_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/crpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module crpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/crpt_alu.sv
// Shared 16-bit add/subtract unit: saturating add with carry, subtract with borrow.
`timescale 1ns / 1ps
`default_nettype none

module crpt_alu
    import crpt_pkg::*;
(
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    logic [DATA_W:0] sum;
    logic [DATA_W:0] diff;

    assign sum  = {1'b0, req.a} + {1'b0, req.b};
    assign diff = {1'b0, req.a} - {1'b0, req.b};

    always_comb
    begin
        case (req.op)
            ALU_ADD:
            begin
                rsp.flag = sum[DATA_W];
                rsp.res  = sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
            end
            ALU_SUB:
            begin
                rsp.flag = diff[DATA_W];
                rsp.res  = diff[DATA_W-1:0];
            end
            default:
            begin
                rsp.flag = 1'b0;
                rsp.res  = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/client_resource_pool_table_top.sv
// Top level of the client resource pool table: sequencer, entry RAM and shared ALU.
`timescale 1ns / 1ps
`default_nettype none
`include "client_resource_pool_table_top_assert.svh"

// A request is taken when start is high and busy is low; its result appears on the
// result ports and holds there until the next one, with done high for exactly one
// cycle, and the receiver cannot stall it. A request walks the entry RAM over the
// clients in the table, one entry per cycle, through its single read port; detach
// then moves the later entries down one per cycle. done is high in the first cycle
// with busy low. A write of cfg_wr_data (with cfg_wr_en) reloads the free pool and
// is made only while busy is low.
module client_resource_pool_table_top
    import crpt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [DATA_W-1:0] cfg_wr_data,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        func,
    input  wire logic [ID_W-1:0]   client_id,
    input  wire logic [DATA_W-1:0] amount,
    output logic                   done,
    output logic      [2:0]        status,
    output logic      [DATA_W-1:0] amount_echo,
    output logic      [DATA_W-1:0] free_now,
    output logic      [DATA_W-1:0] client_usage,
    output logic      [7:0]        clients_now
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_CALC  = 5'b01000,
        S_SHIFT = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [DATA_W-1:0] use_reg, use_next;
    logic [DATA_W-1:0] tmp_reg, tmp_next;
    logic              flag_reg, flag_next;
    logic [CNT_W-1:0]  src_reg, src_next;
    logic [IDX_W-1:0]  dst_reg, dst_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              done_reg, done_next;

    logic [1:0]        func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [DATA_W-1:0] amount_reg;

    logic [2:0]        res_status_reg, res_status_next;
    logic [DATA_W-1:0] res_echo_reg, res_echo_next;
    logic [DATA_W-1:0] res_free_reg, res_free_next;
    logic [DATA_W-1:0] res_use_reg, res_use_next;
    logic [CNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic [CNT_W+7:0]  res_cnt_ext;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ID_W-1:0]    rd_id;
    logic [DATA_W-1:0]  rd_use;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic             accept;
    logic [CNT_W-1:0] src_m1;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign rd_id  = ram_rdata[ENTRY_W-1:DATA_W];
    assign rd_use = ram_rdata[DATA_W-1:0];
    assign src_m1 = src_reg - 1'b1;

    crpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    crpt_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        free_next       = free_reg;
        iss_next        = iss_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        use_next        = use_reg;
        tmp_next        = tmp_reg;
        flag_next       = flag_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        wr_pend_next    = wr_pend_reg;
        done_next       = 1'b0;
        res_status_next = res_status_reg;
        res_echo_next   = res_echo_reg;
        res_free_next   = res_free_reg;
        res_use_next    = res_use_reg;
        res_cnt_next    = res_cnt_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[IDX_W-1:0];
        ram_wdata       = {id_reg, {DATA_W{1'b0}}};
        ram_raddr       = iss_reg[IDX_W-1:0];
        alu_req.op      = ALU_ADD;
        alu_req.a       = free_reg;
        alu_req.b       = amount_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    free_next = cfg_wr_data;
                end
                if (accept)
                begin
                    iss_next     = '0;
                    chk_vld_next = 1'b0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chk_vld_reg && (rd_id == id_reg))
                begin
                    found_next = 1'b1;
                    slot_next  = chk_idx_reg;
                    use_next   = rd_use;
                    state_next = S_EXEC;
                end
                else if (iss_reg < cnt_reg)
                begin
                    ram_raddr    = iss_reg[IDX_W-1:0];
                    iss_next     = iss_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = iss_reg[IDX_W-1:0];
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (func_reg == FN_ATTACH)
                begin
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                    res_echo_next   = '0;
                    res_free_next   = free_reg;
                    res_use_next    = '0;
                    res_cnt_next    = cnt_reg;
                    if (found_reg)
                    begin
                        res_status_next = ST_DUPLICATE;
                        res_use_next    = use_reg;
                    end
                    else if (cnt_reg >= DEPTH_CNT)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = cnt_reg[IDX_W-1:0];
                        ram_wdata       = {id_reg, {DATA_W{1'b0}}};
                        cnt_next        = cnt_reg + 1'b1;
                        res_status_next = ST_OK;
                        res_cnt_next    = cnt_reg + 1'b1;
                    end
                end
                else if (!found_reg)
                begin
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                    res_status_next = ST_NOT_FOUND;
                    res_echo_next   = (func_reg == FN_DETACH) ? '0 : amount_reg;
                    res_free_next   = free_reg;
                    res_use_next    = '0;
                    res_cnt_next    = cnt_reg;
                end
                else if (func_reg == FN_DETACH)
                begin
                    alu_req.op   = ALU_ADD;
                    alu_req.a    = free_reg;
                    alu_req.b    = use_reg;
                    free_next    = alu_rsp.res;
                    src_next     = CNT_W'(slot_reg) + 1'b1;
                    wr_pend_next = 1'b0;
                    state_next   = S_SHIFT;
                end
                else
                begin
                    alu_req.op = ALU_SUB;
                    alu_req.a  = (func_reg == FN_REQUEST) ? free_reg : use_reg;
                    alu_req.b  = amount_reg;
                    tmp_next   = alu_rsp.res;
                    flag_next  = alu_rsp.flag;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                done_next       = 1'b1;
                state_next      = S_IDLE;
                res_echo_next   = amount_reg;
                res_cnt_next    = cnt_reg;
                res_status_next = ST_DENIED;
                res_free_next   = free_reg;
                res_use_next    = use_reg;
                ram_waddr       = slot_reg;
                alu_req.op      = ALU_ADD;
                alu_req.b       = amount_reg;
                if (func_reg == FN_REQUEST)
                begin
                    // tmp = free - amount, alu = usage + amount
                    alu_req.a = use_reg;
                    if (!flag_reg && !alu_rsp.flag)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = {id_reg, alu_rsp.res};
                        free_next       = tmp_reg;
                        res_status_next = ST_OK;
                        res_free_next   = tmp_reg;
                        res_use_next    = alu_rsp.res;
                    end
                end
                else
                begin
                    // tmp = usage - amount, alu = free + amount, saturating
                    alu_req.a = free_reg;
                    if (!flag_reg)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = {id_reg, tmp_reg};
                        free_next       = alu_rsp.res;
                        res_status_next = ST_OK;
                        res_free_next   = alu_rsp.res;
                        res_use_next    = tmp_reg;
                    end
                end
            end
            S_SHIFT:
            begin
                ram_we    = wr_pend_reg;
                ram_waddr = dst_reg;
                ram_wdata = ram_rdata;
                if (src_reg < cnt_reg)
                begin
                    ram_raddr    = src_reg[IDX_W-1:0];
                    src_next     = src_reg + 1'b1;
                    dst_next     = src_m1[IDX_W-1:0];
                    wr_pend_next = 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        cnt_next        = cnt_reg - 1'b1;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                        res_status_next = ST_OK;
                        res_echo_next   = use_reg;
                        res_free_next   = free_reg;
                        res_use_next    = '0;
                        res_cnt_next    = cnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            free_reg    <= '0;
            iss_reg     <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            flag_reg    <= 1'b0;
            src_reg     <= '0;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            free_reg    <= free_next;
            iss_reg     <= iss_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
            flag_reg    <= flag_next;
            src_reg     <= src_next;
            wr_pend_reg <= wr_pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            id_reg     <= client_id;
            amount_reg <= amount;
        end
        chk_idx_reg    <= chk_idx_next;
        slot_reg       <= slot_next;
        use_reg        <= use_next;
        tmp_reg        <= tmp_next;
        dst_reg        <= dst_next;
        res_status_reg <= res_status_next;
        res_echo_reg   <= res_echo_next;
        res_free_reg   <= res_free_next;
        res_use_reg    <= res_use_next;
        res_cnt_reg    <= res_cnt_next;
    end

    assign res_cnt_ext  = {8'd0, res_cnt_reg};
    assign done         = done_reg;
    assign status       = res_status_reg;
    assign amount_echo  = res_echo_reg;
    assign free_now     = res_free_reg;
    assign client_usage = res_use_reg;
    assign clients_now  = res_cnt_ext[7:0];

    `CRPT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while sequencer busy")
    `CRPT_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not start")
    `CRPT_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    `CRPT_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= DEPTH_CNT, "client count above depth")
    `CRPT_ASSERT_NOW(a_shift_found, state_reg == S_SHIFT, found_reg,
                     "compaction without a matched entry")

endmodule

`default_nettype wire
